[rtl/gps_binary_frame_deframer_assert.svh]
// Assertion macros for the deframer, clocked on clk and disabled in reset
`ifndef GPS_BINARY_FRAME_DEFRAMER_ASSERT_SVH
`define GPS_BINARY_FRAME_DEFRAMER_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication
`define GBFD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define GBFD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define GBFD_ASSERT_IMP(label, ante, cons, msg)
`define GBFD_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

[rtl/gbfd_pkg.sv]
`timescale 1ns / 1ps

package gbfd_pkg;

    localparam int PHASE_W = 4;
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 16;
    localparam int SUM_W   = 15;
    localparam int CHK_W   = 16;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;
    localparam int REG_IDX_W = 2;

    // Frame phase codes
    localparam logic [PHASE_W-1:0] PH_START1 = 4'd0;
    localparam logic [PHASE_W-1:0] PH_START2 = 4'd1;
    localparam logic [PHASE_W-1:0] PH_LEN_HI = 4'd2;
    localparam logic [PHASE_W-1:0] PH_LEN_LO = 4'd3;
    localparam logic [PHASE_W-1:0] PH_ID     = 4'd4;
    localparam logic [PHASE_W-1:0] PH_PAYLD  = 4'd5;
    localparam logic [PHASE_W-1:0] PH_CK_HI  = 4'd6;
    localparam logic [PHASE_W-1:0] PH_CK_LO  = 4'd7;
    localparam logic [PHASE_W-1:0] PH_END1   = 4'd8;
    localparam logic [PHASE_W-1:0] PH_END2   = 4'd9;
    localparam logic [PHASE_W-1:0] PH_DONE   = 4'd10;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_START1 = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_START2 = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_END1   = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_END2   = 2'd3;

    // Register reset values
    localparam logic [BYTE_W-1:0] RST_START1 = 8'd160;
    localparam logic [BYTE_W-1:0] RST_START2 = 8'd162;
    localparam logic [BYTE_W-1:0] RST_END1   = 8'd176;
    localparam logic [BYTE_W-1:0] RST_END2   = 8'd179;

    // One result of the frame walk
    typedef struct packed {
        logic [PHASE_W-1:0] next_phase;
        logic               byte_consumed;
        logic               payload_valid;
        logic [BYTE_W-1:0]  payload_byte;
        logic [BYTE_W-1:0]  frame_id;
        logic               frame_done;
        logic               checksum_ok;
    } result_t;

endpackage

[rtl/gbfd_if.sv]
`timescale 1ns / 1ps

// Received byte channel
interface gbfd_byte_if;
    logic                          valid;
    logic                          ready;
    logic [gbfd_pkg::BYTE_W-1:0]   rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// Deframer result channel
interface gbfd_result_if;
    logic                          valid;
    logic                          ready;
    logic [gbfd_pkg::PHASE_W-1:0]  next_phase;
    logic                          byte_consumed;
    logic                          payload_valid;
    logic [gbfd_pkg::BYTE_W-1:0]   payload_byte;
    logic [gbfd_pkg::BYTE_W-1:0]   frame_id;
    logic                          frame_done;
    logic                          checksum_ok;

    modport source (output valid, output next_phase, output byte_consumed,
                    output payload_valid, output payload_byte, output frame_id,
                    output frame_done, output checksum_ok, input ready);
    modport sink   (input valid, input next_phase, input byte_consumed,
                    input payload_valid, input payload_byte, input frame_id,
                    input frame_done, input checksum_ok, output ready);
endinterface

[rtl/gps_binary_frame_deframer.sv]
`timescale 1ns / 1ps
// Each accepted byte is held in the input register, then in the result register; the frame
// state updates as the byte leaves the input register.
// Throughput: one byte per cycle while the result channel is ready; the frame state updates on each step.
// Reset: rst_n asynchronous active low; clears both stages, the frame state to
// waiting for the first start sync, and the sync registers to their defaults.
module gps_binary_frame_deframer
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [gbfd_pkg::ADDR_W-1:0]    paddr,
    input  logic [gbfd_pkg::DATA_W-1:0]    pwdata,
    output logic [gbfd_pkg::DATA_W-1:0]    prdata,
    output logic                           pready,
    gbfd_byte_if.sink                      byte_in,
    gbfd_result_if.source                  result_out
);

    // Sync registers
    logic [gbfd_pkg::BYTE_W-1:0] start1_reg;
    logic [gbfd_pkg::BYTE_W-1:0] start2_reg;
    logic [gbfd_pkg::BYTE_W-1:0] end1_reg;
    logic [gbfd_pkg::BYTE_W-1:0] end2_reg;
    logic [gbfd_pkg::REG_IDX_W-1:0] reg_idx;
    logic cfg_wr;

    // Pipeline
    logic                        in_valid_reg;
    logic [gbfd_pkg::BYTE_W-1:0] in_byte_reg;
    logic                        out_valid_reg;
    gbfd_pkg::result_t           out_reg;
    gbfd_pkg::result_t           res_next;
    logic                        out_free;
    logic                        step;

    // Frame state
    logic [gbfd_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [gbfd_pkg::LEN_W-1:0]   remain_reg, remain_next;
    logic [gbfd_pkg::BYTE_W-1:0]  id_reg, id_next;
    logic [gbfd_pkg::SUM_W-1:0]   sum_reg, sum_next;
    logic [gbfd_pkg::CHK_W-1:0]   check_reg, check_next;

    logic [gbfd_pkg::SUM_W-1:0]   sum_add;
    logic [gbfd_pkg::LEN_W-1:0]   len_full;
    logic [gbfd_pkg::LEN_W-1:0]   remain_dec;

    // Configuration port
    assign pready  = 1'b1;
    assign reg_idx = paddr[gbfd_pkg::ADDR_W-1:gbfd_pkg::ADDR_W-gbfd_pkg::REG_IDX_W];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start1_reg <= gbfd_pkg::RST_START1;
            start2_reg <= gbfd_pkg::RST_START2;
            end1_reg   <= gbfd_pkg::RST_END1;
            end2_reg   <= gbfd_pkg::RST_END2;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                gbfd_pkg::REG_START1: start1_reg <= pwdata[gbfd_pkg::BYTE_W-1:0];
                gbfd_pkg::REG_START2: start2_reg <= pwdata[gbfd_pkg::BYTE_W-1:0];
                gbfd_pkg::REG_END1:   end1_reg   <= pwdata[gbfd_pkg::BYTE_W-1:0];
                gbfd_pkg::REG_END2:   end2_reg   <= pwdata[gbfd_pkg::BYTE_W-1:0];
                default:              start1_reg <= start1_reg;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            gbfd_pkg::REG_START1: prdata[gbfd_pkg::BYTE_W-1:0] = start1_reg;
            gbfd_pkg::REG_START2: prdata[gbfd_pkg::BYTE_W-1:0] = start2_reg;
            gbfd_pkg::REG_END1:   prdata[gbfd_pkg::BYTE_W-1:0] = end1_reg;
            gbfd_pkg::REG_END2:   prdata[gbfd_pkg::BYTE_W-1:0] = end2_reg;
            default:              prdata = '0;
        endcase
    end

    // Handshake: advance the input stage when the result register is free
    assign out_free      = !out_valid_reg || result_out.ready;
    assign step          = in_valid_reg && out_free;
    assign byte_in.ready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (byte_in.ready)
                in_valid_reg <= byte_in.valid;
            if (out_free)
                out_valid_reg <= in_valid_reg;
        end
    end

    // Hold payloads until their request moves on
    always_ff @(posedge clk)
    begin
        if (byte_in.ready && byte_in.valid)
            in_byte_reg <= byte_in.rx_byte;
        if (step)
            out_reg <= res_next;
    end

    // Frame walk
    assign sum_add    = sum_reg + {{(gbfd_pkg::SUM_W-gbfd_pkg::BYTE_W){1'b0}}, in_byte_reg};
    assign len_full   = {remain_reg[gbfd_pkg::LEN_W-1:gbfd_pkg::BYTE_W], in_byte_reg};
    assign remain_dec = remain_reg - 16'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        remain_next = remain_reg;
        id_next     = id_reg;
        sum_next    = sum_reg;
        check_next  = check_reg;
        res_next    = '0;

        unique case (phase_reg)
            gbfd_pkg::PH_START1:
            begin
                if (in_byte_reg == start1_reg)
                begin
                    remain_next = '0;
                    id_next     = '0;
                    sum_next    = '0;
                    check_next  = '0;
                    phase_next  = gbfd_pkg::PH_START2;
                    res_next.byte_consumed = 1'b1;
                end
            end
            gbfd_pkg::PH_START2:
            begin
                if (in_byte_reg == start2_reg)
                begin
                    phase_next = gbfd_pkg::PH_LEN_HI;
                    res_next.byte_consumed = 1'b1;
                end
            end
            gbfd_pkg::PH_LEN_HI:
            begin
                remain_next = {in_byte_reg, 8'd0};
                phase_next  = gbfd_pkg::PH_LEN_LO;
                res_next.byte_consumed = 1'b1;
            end
            gbfd_pkg::PH_LEN_LO:
            begin
                // Length counts the id byte; saturate at zero
                remain_next = (len_full != '0) ? len_full - 16'd1 : len_full;
                phase_next  = gbfd_pkg::PH_ID;
                res_next.byte_consumed = 1'b1;
            end
            gbfd_pkg::PH_ID:
            begin
                sum_next   = sum_add;
                id_next    = in_byte_reg;
                phase_next = (remain_reg != '0) ? gbfd_pkg::PH_PAYLD : gbfd_pkg::PH_CK_HI;
                res_next.byte_consumed = 1'b1;
            end
            gbfd_pkg::PH_PAYLD:
            begin
                sum_next = sum_add;
                res_next.payload_valid = 1'b1;
                res_next.payload_byte  = in_byte_reg;
                res_next.byte_consumed = 1'b1;
                if (remain_reg != '0)
                    remain_next = remain_dec;
                if (remain_reg <= 16'd1)
                    phase_next = gbfd_pkg::PH_CK_HI;
            end
            gbfd_pkg::PH_CK_HI:
            begin
                check_next = {in_byte_reg, 8'd0};
                phase_next = gbfd_pkg::PH_CK_LO;
                res_next.byte_consumed = 1'b1;
            end
            gbfd_pkg::PH_CK_LO:
            begin
                check_next = {check_reg[gbfd_pkg::CHK_W-1:gbfd_pkg::BYTE_W], in_byte_reg};
                phase_next = gbfd_pkg::PH_END1;
                res_next.byte_consumed = 1'b1;
            end
            gbfd_pkg::PH_END1:
            begin
                if (in_byte_reg == end1_reg)
                begin
                    phase_next = gbfd_pkg::PH_END2;
                    res_next.byte_consumed = 1'b1;
                end
            end
            gbfd_pkg::PH_END2:
            begin
                if (in_byte_reg == end2_reg)
                begin
                    res_next.byte_consumed = 1'b1;
                    res_next.frame_done    = 1'b1;
                    res_next.checksum_ok   = ({1'b0, sum_reg} == check_reg);
                end
            end
            default:
            begin
                phase_next = gbfd_pkg::PH_START1;
            end
        endcase

        // Report against the id before the frame is dropped
        res_next.frame_id   = id_next;
        res_next.next_phase = res_next.frame_done ? gbfd_pkg::PH_DONE : phase_next;

        // Return to idle after a completed frame
        if (res_next.frame_done)
        begin
            phase_next  = gbfd_pkg::PH_START1;
            remain_next = '0;
            id_next     = '0;
            sum_next    = '0;
            check_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= gbfd_pkg::PH_START1;
            remain_reg <= '0;
            id_reg     <= '0;
            sum_reg    <= '0;
            check_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            remain_reg <= remain_next;
            id_reg     <= id_next;
            sum_reg    <= sum_next;
            check_reg  <= check_next;
        end
    end

    // Drive the result channel
    assign result_out.valid         = out_valid_reg;
    assign result_out.next_phase    = out_reg.next_phase;
    assign result_out.byte_consumed = out_reg.byte_consumed;
    assign result_out.payload_valid = out_reg.payload_valid;
    assign result_out.payload_byte  = out_reg.payload_byte;
    assign result_out.frame_id      = out_reg.frame_id;
    assign result_out.frame_done    = out_reg.frame_done;
    assign result_out.checksum_ok   = out_reg.checksum_ok;

    // Checks
    `include "gps_binary_frame_deframer_assert.svh"

    `GBFD_ASSERT_IMP(a_phase_range, 1'b1, phase_reg <= gbfd_pkg::PH_END2, "phase out of range")
    `GBFD_ASSERT_IMP(a_done_shape, out_valid_reg && out_reg.frame_done, out_reg.byte_consumed && (out_reg.next_phase == gbfd_pkg::PH_DONE), "bad completion result")
    `GBFD_ASSERT_IMP(a_ok_needs_done, out_valid_reg && out_reg.checksum_ok, out_reg.frame_done, "checksum_ok without frame_done")
    `GBFD_ASSERT_NXT(a_done_to_idle, step && res_next.frame_done, phase_reg == gbfd_pkg::PH_START1 && sum_reg == '0, "frame state not cleared")

endmodule

[dv/tb_gps_binary_frame_deframer.sv]
`timescale 1ns / 1ps

module tb_gps_binary_frame_deframer;

    localparam int unsigned STALL_LIMIT = 5000;

    typedef logic [gbfd_pkg::BYTE_W-1:0]    byte_t;
    typedef logic [gbfd_pkg::LEN_W-1:0]     len_t;
    typedef logic [gbfd_pkg::SUM_W-1:0]     sum_t;
    typedef logic [gbfd_pkg::CHK_W-1:0]     chk_t;
    typedef logic [gbfd_pkg::PHASE_W-1:0]   phase_t;
    typedef logic [gbfd_pkg::REG_IDX_W-1:0] idx_t;

    // Kinds of checksum placed in a generated frame
    typedef enum int
    {
        CK_GOOD,
        CK_RANDOM,
        CK_TOP_BIT
    } ck_kind_t;

    // Tracks the frame walk and holds the results it predicts
    class frame_walk_tracker;
        byte_t                  sync_value [4];
        phase_t                 phase;
        len_t                   remaining;
        byte_t                  cur_id;
        sum_t                   sum;
        chk_t                   rx_check;
        gbfd_pkg::result_t      predicted [$];

        function new();
            sync_value[gbfd_pkg::REG_START1] = gbfd_pkg::RST_START1;
            sync_value[gbfd_pkg::REG_START2] = gbfd_pkg::RST_START2;
            sync_value[gbfd_pkg::REG_END1]   = gbfd_pkg::RST_END1;
            sync_value[gbfd_pkg::REG_END2]   = gbfd_pkg::RST_END2;
            phase = gbfd_pkg::PH_START1;
            clear_frame();
        endfunction

        function void clear_frame();
            remaining = '0;
            cur_id    = '0;
            sum       = '0;
            rx_check  = '0;
        endfunction

        function void set_sync(input idx_t idx, input byte_t val);
            sync_value[idx] = val;
        endfunction

        function int unsigned outstanding();
            return predicted.size();
        endfunction

        // Advance the frame state by one byte and return what the block shows
        function gbfd_pkg::result_t walk_byte(input byte_t b);
            gbfd_pkg::result_t r;
            r = '0;
            case (phase)
                gbfd_pkg::PH_START1:
                    if (b == sync_value[gbfd_pkg::REG_START1])
                    begin
                        clear_frame();
                        phase = gbfd_pkg::PH_START2;
                        r.byte_consumed = 1'b1;
                    end
                gbfd_pkg::PH_START2:
                    if (b == sync_value[gbfd_pkg::REG_START2])
                    begin
                        phase = gbfd_pkg::PH_LEN_HI;
                        r.byte_consumed = 1'b1;
                    end
                gbfd_pkg::PH_LEN_HI:
                begin
                    remaining = {b, 8'h00};
                    phase = gbfd_pkg::PH_LEN_LO;
                    r.byte_consumed = 1'b1;
                end
                gbfd_pkg::PH_LEN_LO:
                begin
                    remaining = {remaining[15:8], b};
                    // the length counts the id byte
                    if (remaining != '0)
                        remaining = remaining - 16'd1;
                    phase = gbfd_pkg::PH_ID;
                    r.byte_consumed = 1'b1;
                end
                gbfd_pkg::PH_ID:
                begin
                    sum = sum + {7'd0, b};
                    cur_id = b;
                    phase = (remaining != '0) ? gbfd_pkg::PH_PAYLD : gbfd_pkg::PH_CK_HI;
                    r.byte_consumed = 1'b1;
                end
                gbfd_pkg::PH_PAYLD:
                begin
                    sum = sum + {7'd0, b};
                    r.payload_valid = 1'b1;
                    r.payload_byte = b;
                    if (remaining != '0)
                        remaining = remaining - 16'd1;
                    if (remaining == '0)
                        phase = gbfd_pkg::PH_CK_HI;
                    r.byte_consumed = 1'b1;
                end
                gbfd_pkg::PH_CK_HI:
                begin
                    rx_check = {b, 8'h00};
                    phase = gbfd_pkg::PH_CK_LO;
                    r.byte_consumed = 1'b1;
                end
                gbfd_pkg::PH_CK_LO:
                begin
                    rx_check = {rx_check[15:8], b};
                    phase = gbfd_pkg::PH_END1;
                    r.byte_consumed = 1'b1;
                end
                gbfd_pkg::PH_END1:
                    if (b == sync_value[gbfd_pkg::REG_END1])
                    begin
                        phase = gbfd_pkg::PH_END2;
                        r.byte_consumed = 1'b1;
                    end
                gbfd_pkg::PH_END2:
                    if (b == sync_value[gbfd_pkg::REG_END2])
                    begin
                        r.byte_consumed = 1'b1;
                        r.frame_done = 1'b1;
                        // a received top bit can never match the 15-bit sum
                        r.checksum_ok = ({1'b0, sum} == rx_check);
                    end
                default:
                    phase = gbfd_pkg::PH_START1;
            endcase
            r.next_phase = r.frame_done ? gbfd_pkg::PH_DONE : phase;
            r.frame_id = cur_id;
            if (r.frame_done)
            begin
                phase = gbfd_pkg::PH_START1;
                clear_frame();
            end
            return r;
        endfunction

        function void accept_byte(input byte_t b);
            predicted.push_back(walk_byte(b));
        endfunction

        // Compare a result with the oldest prediction; empty string when it matches
        function string match_result(input gbfd_pkg::result_t got);
            gbfd_pkg::result_t exp;
            string             diff;
            diff = "";
            if (predicted.size() == 0)
                return " result with nothing predicted";
            exp = predicted.pop_front();
            if (got.next_phase !== exp.next_phase)
                diff = {diff, $sformatf(" next_phase %0d/%0d", got.next_phase, exp.next_phase)};
            if (got.byte_consumed !== exp.byte_consumed)
                diff = {diff, $sformatf(" byte_consumed %0d/%0d",
                                        got.byte_consumed, exp.byte_consumed)};
            if (got.payload_valid !== exp.payload_valid)
                diff = {diff, $sformatf(" payload_valid %0d/%0d",
                                        got.payload_valid, exp.payload_valid)};
            if (got.payload_byte !== exp.payload_byte)
                diff = {diff, $sformatf(" payload_byte %h/%h", got.payload_byte, exp.payload_byte)};
            if (got.frame_id !== exp.frame_id)
                diff = {diff, $sformatf(" frame_id %h/%h", got.frame_id, exp.frame_id)};
            if (got.frame_done !== exp.frame_done)
                diff = {diff, $sformatf(" frame_done %0d/%0d", got.frame_done, exp.frame_done)};
            if (got.checksum_ok !== exp.checksum_ok)
                diff = {diff, $sformatf(" checksum_ok %0d/%0d", got.checksum_ok, exp.checksum_ok)};
            return diff;
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [gbfd_pkg::ADDR_W-1:0]   paddr;
    logic [gbfd_pkg::DATA_W-1:0]   pwdata;
    logic [gbfd_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    gbfd_byte_if   byte_ch ();
    gbfd_result_if result_ch ();

    frame_walk_tracker tracker = new();

    byte_t             sync_cfg [4] = '{gbfd_pkg::RST_START1, gbfd_pkg::RST_START2,
                                        gbfd_pkg::RST_END1, gbfd_pkg::RST_END2};
    byte_t             tx_bytes [$];
    int unsigned       send_idle_pct;
    int unsigned       recv_idle_pct;
    int unsigned       mismatch_count;

    gps_binary_frame_deframer DUT
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .byte_in    (byte_ch),
        .result_out (result_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Stall the result side at random
    always @(posedge clk)
    begin
        result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("%0t ns: result mismatch:%s", $time, what);
    endtask

    // Note accepted bytes and check accepted results
    always @(posedge clk)
    begin : result_monitor
        gbfd_pkg::result_t seen;
        string             diff;
        if (rst_n)
        begin
            if (byte_ch.valid && byte_ch.ready)
                tracker.accept_byte(byte_ch.rx_byte);
            if (result_ch.valid && result_ch.ready)
            begin
                seen.next_phase    = result_ch.next_phase;
                seen.byte_consumed = result_ch.byte_consumed;
                seen.payload_valid = result_ch.payload_valid;
                seen.payload_byte  = result_ch.payload_byte;
                seen.frame_id      = result_ch.frame_id;
                seen.frame_done    = result_ch.frame_done;
                seen.checksum_ok   = result_ch.checksum_ok;
                diff = tracker.match_result(seen);
                if (diff != "")
                    report_mismatch(diff);
            end
        end
    end

    // Drop the run when nothing moves for too long
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_gps_binary_frame_deframer: errors");
        $finish;
    end

    // One register write: setup cycle, then access cycle
    task automatic reg_write(input idx_t idx, input byte_t val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(gbfd_pkg::DATA_W-gbfd_pkg::BYTE_W){1'b0}}, val};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.set_sync(idx, val);
        sync_cfg[idx] = val;
    endtask

    task automatic program_syncs(input byte_t s1, input byte_t s2,
                                 input byte_t e1, input byte_t e2);
        reg_write(gbfd_pkg::REG_START1, s1);
        reg_write(gbfd_pkg::REG_START2, s2);
        reg_write(gbfd_pkg::REG_END1, e1);
        reg_write(gbfd_pkg::REG_END2, e2);
    endtask

    // Queue a byte that differs from the given sync value, so it is held
    task automatic push_other(input byte_t avoid);
        byte_t b;
        b = byte_t'($urandom_range(255));
        while (b == avoid)
            b = byte_t'($urandom_range(255));
        tx_bytes.push_back(b);
    endtask

    // Queue one frame; noisy puts a held mismatch before each later sync byte
    task automatic add_frame(input len_t len_field, input byte_t msg_id,
                             input ck_kind_t ck_kind, input bit noisy, input bit heavy);
        sum_t        s;
        chk_t        ck;
        byte_t       pb;
        int unsigned n;
        s = {7'd0, msg_id};
        tx_bytes.push_back(sync_cfg[gbfd_pkg::REG_START1]);
        if (noisy)
            push_other(sync_cfg[gbfd_pkg::REG_START2]);
        tx_bytes.push_back(sync_cfg[gbfd_pkg::REG_START2]);
        tx_bytes.push_back(len_field[15:8]);
        tx_bytes.push_back(len_field[7:0]);
        tx_bytes.push_back(msg_id);
        n = (len_field == '0) ? 0 : int'(len_field) - 1;
        for (int unsigned i = 0; i < n; i++)
        begin
            pb = heavy ? byte_t'($urandom_range(255, 128)) : byte_t'($urandom_range(255));
            s = s + {7'd0, pb};
            tx_bytes.push_back(pb);
        end
        case (ck_kind)
            CK_GOOD:    ck = {1'b0, s};
            CK_RANDOM:  ck = chk_t'($urandom_range(16'hFFFF));
            default:    ck = {1'b1, s};
        endcase
        tx_bytes.push_back(ck[15:8]);
        tx_bytes.push_back(ck[7:0]);
        if (noisy)
            push_other(sync_cfg[gbfd_pkg::REG_END1]);
        tx_bytes.push_back(sync_cfg[gbfd_pkg::REG_END1]);
        if (noisy)
            push_other(sync_cfg[gbfd_pkg::REG_END2]);
        tx_bytes.push_back(sync_cfg[gbfd_pkg::REG_END2]);
    endtask

    // Send every queued byte as a request, idling the sender at random
    task automatic send_bytes();
        while (tx_bytes.size() != 0)
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                byte_ch.valid <= 1'b0;
                @(posedge clk);
            end
            byte_ch.valid   <= 1'b1;
            byte_ch.rx_byte <= tx_bytes.pop_front();
            do @(posedge clk); while (!byte_ch.ready);
        end
        byte_ch.valid <= 1'b0;
    endtask

    // Build mostly well-formed frames with noise and truncated starts, then send
    task automatic run_traffic(input int unsigned quota);
        int unsigned pick;
        int unsigned plen;
        len_t        lf;
        ck_kind_t    kind;
        while (tx_bytes.size() < quota)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
            begin
                repeat ($urandom_range(3, 1))
                    push_other(sync_cfg[gbfd_pkg::REG_START1]);
            end
            else
            begin
                // lone start byte: the next frame's start byte is then held
                if (pick < 14 && sync_cfg[gbfd_pkg::REG_START1] != sync_cfg[gbfd_pkg::REG_START2])
                    tx_bytes.push_back(sync_cfg[gbfd_pkg::REG_START1]);
                plen = $urandom_range(10);
                lf = ($urandom_range(9) == 0) ? '0 : len_t'(plen + 1);
                pick = $urandom_range(99);
                kind = (pick < 70) ? CK_GOOD : ((pick < 85) ? CK_RANDOM : CK_TOP_BIT);
                add_frame(lf, byte_t'($urandom_range(255)), kind, $urandom_range(3) == 0, 1'b0);
            end
        end
        send_bytes();
    endtask

    // Hold until every predicted result has arrived and the pipeline is empty
    task automatic drain();
        @(posedge clk);
        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        mismatch_count  = 0;
        send_idle_pct   = 31;
        recv_idle_pct   = 67;
        rst_n           = 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        byte_ch.valid  <= 1'b0;
        byte_ch.rx_byte <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames at reset sync values: zero length with held mismatches,
        // length one with the checksum top bit set, one payload byte
        add_frame(16'h0000, 8'hFF, CK_GOOD, 1'b1, 1'b0);
        add_frame(16'h0001, 8'h00, CK_TOP_BIT, 1'b0, 1'b0);
        add_frame(16'h0002, 8'h5A, CK_GOOD, 1'b0, 1'b0);
        send_bytes();
        drain();

        // Extreme sync values, receiver mostly stalled
        program_syncs(8'h00, 8'hFF, 8'hFF, 8'h00);
        run_traffic(60);
        drain();

        // Random sync values, sender mostly idle
        send_idle_pct = 67;
        recv_idle_pct = 31;
        program_syncs(byte_t'($urandom_range(255)), byte_t'($urandom_range(255)),
                      byte_t'($urandom_range(255)), byte_t'($urandom_range(255)));
        run_traffic(60);
        drain();

        // Opposite extremes at full rate, with a long frame that wraps the sum
        send_idle_pct = 0;
        recv_idle_pct = 0;
        program_syncs(8'hFF, 8'h00, 8'h00, 8'hFF);
        add_frame(16'd201, byte_t'($urandom_range(255)), CK_GOOD, 1'b0, 1'b1);
        run_traffic(290);
        drain();

        if (mismatch_count == 0)
            $display("tb_gps_binary_frame_deframer: clean");
        else
            $display("tb_gps_binary_frame_deframer: errors");
        $finish;
    end

endmodule

[gps_binary_frame_deframer.f]
+incdir+rtl
rtl/gbfd_pkg.sv
rtl/gbfd_if.sv
rtl/gps_binary_frame_deframer.sv
dv/tb_gps_binary_frame_deframer.sv
